// File: rtl/resource_range_validator_macros.svh
// Assertion macros for the resource range validator
`ifndef RESOURCE_RANGE_VALIDATOR_MACROS_SVH
`define RESOURCE_RANGE_VALIDATOR_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define RRV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define RRV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/rrv_pkg.sv
// Shared types and constants of the resource range validator
package rrv_pkg;
    localparam int ENTRY_DEPTH = 256;
    localparam int GROUP_DEPTH = 64;
    localparam int EA_W = $clog2(ENTRY_DEPTH);
    localparam int EC_W = $clog2(ENTRY_DEPTH + 1);
    localparam int GA_W = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int GC_W = $clog2(GROUP_DEPTH + 1);
    localparam logic [7:0] ALL_HOSTS_RESET = 8'd128;
    localparam int PADDR_W = 1;
    localparam logic [PADDR_W-1:0] REG_ALL_HOSTS = 1'b0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_ASSN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic        op;
        logic [15:0] utype;
        logic [7:0]  host;
        logic [15:0] rsrc_idx;
        logic [15:0] entry_start;
        logic [15:0] entry_num;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] prim_base;
        logic [15:0] prim_count;
        logic [15:0] sec_base;
        logic [15:0] sec_count;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;    // capture input item
        logic do_store;    // write entry / group
        logic set_ovf;     // refuse the load
        logic srch_init;   // start group search for the current host
        logic srch_step;   // probe group at midpoint
        logic scan_init;   // start walking the found group
        logic scan_rd;     // issue entry read
        logic scan_eval;   // evaluate read entry
        logic save_prim;   // keep requester ranges
        logic use_all;     // next pass uses all_hosts_id
        logic set_result;  // load output register
        logic res_ok;      // result status select
        logic res_ovf;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_query;
        logic refuse;       // load would overflow
        logic srch_done;
        logic srch_found;
        logic scan_done;
        logic hit;          // index inside current ranges
    } sts_t;
endpackage

// File: rtl/rrv_stream_if.sv
// Valid/ready channel carrying one payload
interface rrv_stream_if #(type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rrv_ctrl.sv
// Sequencing state machine of the validator
module rrv_ctrl import rrv_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SRCH, S_SCAN_RD, S_SCAN_EV, S_CHECK, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;       // 0 requester pass, 1 all-hosts pass
    logic   ovalid_reg, ovalid_next;

    assign out_valid = ovalid_reg;
    assign in_ready  = (state_reg == S_IDLE) && (!ovalid_reg || out_ready);

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        pass_next   = pass_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!sts.is_query)
                begin
                    // answer from the table state before this load
                    cmd.do_store   = !sts.refuse;
                    cmd.set_ovf    = sts.refuse;
                    cmd.set_result = 1'b1;
                    cmd.res_ok     = !sts.refuse;
                    cmd.res_ovf    = sts.refuse;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.srch_init = 1'b1;
                    pass_next     = 1'b0;
                    state_next    = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (sts.srch_done)
                begin
                    if (sts.srch_found)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    cmd.srch_step = 1'b1;
                end
            end
            S_SCAN_RD:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                state_next    = S_SCAN_RD;
            end
            S_CHECK:
            begin
                if (!pass_reg)
                begin
                    cmd.save_prim = 1'b1;
                end
                // drop to all-hosts pass on a miss in the requester pass
                if (sts.hit || pass_reg)
                begin
                    cmd.res_ok = sts.hit;
                    state_next = S_OUT;
                    cmd.set_result = 1'b1;
                end
                else
                begin
                    cmd.use_all   = 1'b1;
                    cmd.srch_init = 1'b1;
                    pass_next     = 1'b1;
                    state_next    = S_SRCH;
                end
            end
            S_OUT:
            begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // hold state, pass and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pass_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule

// File: rtl/rrv_datapath.sv
// Table storage, group search and range test of the validator
module rrv_datapath import rrv_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  req_t       in_data,
    input  logic [7:0] all_hosts_id,
    output sts_t       sts,
    output rsp_t       rsp
);
    // memories
    logic [55:0] entry_mem [ENTRY_DEPTH];
    logic [15:0] grp_ut_mem [GROUP_DEPTH];
    logic [EA_W-1:0] grp_first_mem [GROUP_DEPTH];
    logic [EC_W-1:0] grp_len_mem [GROUP_DEPTH];

    req_t            req_reg;
    logic [EC_W-1:0] ecount_reg;
    logic [GC_W-1:0] gcount_reg;
    logic            ovf_reg;
    logic [15:0]     last_ut_reg;
    logic [EC_W-1:0] last_len_reg;

    // search state: upper bound kept one above to stay unsigned
    logic [GC_W:0]   lo_reg, hi1_reg;   // hi1 = hi + 1
    logic [GC_W-1:0] cnt_reg;
    logic            found_reg, sdone_reg;
    logic [GA_W-1:0] gsel_reg;
    logic            probe_reg;
    logic [15:0]     gu_rd_reg;
    logic [GA_W-1:0] cur_reg;

    // scan state
    logic [EC_W-1:0] eaddr_reg, eend_reg;
    logic            sc_done_reg;
    logic [55:0]     ent_rd_reg;
    logic [7:0]      qhost_reg;
    logic [15:0]     r0_reg, r1_reg, r2_reg, r3_reg;
    logic [15:0]     p0_reg, p1_reg, p2_reg, p3_reg;

    logic            new_grp, refuse;
    logic [GC_W:0]   mid;
    logic            ent_match;

    assign new_grp = (gcount_reg == '0) || (last_ut_reg != req_reg.utype);
    assign refuse  = ovf_reg || (ecount_reg >= EC_W'(ENTRY_DEPTH)) ||
                     (new_grp && (gcount_reg >= GC_W'(GROUP_DEPTH)));
    assign mid     = (lo_reg + hi1_reg - 1'b1) >> 1;

    // entry layout: utype, host, start, count
    assign ent_match = (ent_rd_reg[39:32] == qhost_reg) &&
                       (ent_rd_reg[55:40] == req_reg.utype);

    // ranges test in 17 bits
    function automatic logic in_rng(logic [15:0] idx, logic [15:0] s, logic [15:0] n);
        logic [16:0] e;
        e = {1'b0, s} + {1'b0, n};
        return (idx >= s) && ({1'b0, idx} < e);
    endfunction

    assign sts.is_query   = req_reg.op;
    assign sts.refuse     = refuse;
    assign sts.srch_done  = sdone_reg;
    assign sts.srch_found = found_reg;
    assign sts.scan_done  = sc_done_reg;
    assign sts.hit        = in_rng(req_reg.rsrc_idx, r0_reg, r1_reg) ||
                            in_rng(req_reg.rsrc_idx, r2_reg, r3_reg);

    // write table entries and group index
    always_ff @(posedge clk)
    begin
        if (cmd.do_store)
        begin
            entry_mem[ecount_reg[EA_W-1:0]] <= {req_reg.utype, req_reg.host,
                                                req_reg.entry_start, req_reg.entry_num};
            if (new_grp)
            begin
                grp_ut_mem[gcount_reg[GA_W-1:0]]    <= req_reg.utype;
                grp_first_mem[gcount_reg[GA_W-1:0]] <= ecount_reg[EA_W-1:0];
                grp_len_mem[gcount_reg[GA_W-1:0]]   <= EC_W'(1);
            end
            else
            begin
                grp_len_mem[gcount_reg[GA_W-1:0] - 1'b1] <= last_len_reg + 1'b1;
            end
        end
    end

    // table counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecount_reg   <= '0;
            gcount_reg   <= '0;
            ovf_reg      <= 1'b0;
            last_ut_reg  <= '0;
            last_len_reg <= '0;
        end
        else
        begin
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.do_store)
            begin
                ecount_reg  <= ecount_reg + 1'b1;
                last_ut_reg <= req_reg.utype;
                if (new_grp)
                begin
                    gcount_reg   <= gcount_reg + 1'b1;
                    last_len_reg <= EC_W'(1);
                end
                else
                begin
                    last_len_reg <= last_len_reg + 1'b1;
                end
            end
        end
    end

    // capture request
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= in_data;
        end
    end

    // binary search: read group utype, then compare
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sdone_reg <= 1'b0;
            found_reg <= 1'b0;
            probe_reg <= 1'b0;
            lo_reg    <= '0;
            hi1_reg   <= '0;
            cnt_reg   <= '0;
            gsel_reg  <= '0;
            gu_rd_reg <= '0;
            cur_reg   <= '0;
            qhost_reg <= '0;
        end
        else if (cmd.srch_init)
        begin
            lo_reg    <= '0;
            hi1_reg   <= {1'b0, gcount_reg};
            cnt_reg   <= gcount_reg;
            found_reg <= 1'b0;
            sdone_reg <= (gcount_reg == '0);
            probe_reg <= 1'b0;
            qhost_reg <= cmd.use_all ? all_hosts_id : req_reg.host;
        end
        else if (cmd.srch_step)
        begin
            if (!probe_reg)
            begin
                cur_reg   <= mid[GA_W-1:0];
                gu_rd_reg <= grp_ut_mem[mid[GA_W-1:0]];
                probe_reg <= 1'b1;
            end
            else
            begin
                probe_reg <= 1'b0;
                if (gu_rd_reg == req_reg.utype)
                begin
                    found_reg <= 1'b1;
                    sdone_reg <= 1'b1;
                    gsel_reg  <= cur_reg;
                end
                else if (gu_rd_reg < req_reg.utype)
                begin
                    lo_reg  <= {1'b0, (GC_W)'(cur_reg)} + 1'b1;
                    cnt_reg <= cnt_reg - 1'b1;
                    sdone_reg <= ({1'b0, (GC_W)'(cur_reg)} + 1'b1 >= hi1_reg) ||
                                 (cnt_reg == GC_W'(1));
                end
                else
                begin
                    hi1_reg <= {1'b0, (GC_W)'(cur_reg)};
                    cnt_reg <= cnt_reg - 1'b1;
                    sdone_reg <= ({1'b0, (GC_W)'(cur_reg)} <= lo_reg) ||
                                 (cnt_reg == GC_W'(1));
                end
            end
        end
    end

    // group walk over entries
    always_ff @(posedge clk)
    begin
        if (cmd.srch_init)
        begin
            r0_reg <= '0;
            r1_reg <= '0;
            r2_reg <= '0;
            r3_reg <= '0;
            sc_done_reg <= 1'b0;
        end
        if (cmd.scan_init)
        begin
            eaddr_reg   <= EC_W'(grp_first_mem[gsel_reg]);
            eend_reg    <= EC_W'(grp_first_mem[gsel_reg]) + grp_len_mem[gsel_reg];
            sc_done_reg <= (grp_len_mem[gsel_reg] == '0);
        end
        if (cmd.scan_rd)
        begin
            ent_rd_reg <= entry_mem[eaddr_reg[EA_W-1:0]];
        end
        if (cmd.scan_eval)
        begin
            eaddr_reg <= eaddr_reg + 1'b1;
            // stop at the group end or once the secondary slot is filled
            sc_done_reg <= (eaddr_reg + 1'b1 >= eend_reg) ||
                           (ent_match && (r1_reg != '0));
            if (ent_match)
            begin
                if (r1_reg == '0)
                begin
                    r0_reg <= ent_rd_reg[31:16];
                    r1_reg <= ent_rd_reg[15:0];
                end
                else
                begin
                    r2_reg <= ent_rd_reg[31:16];
                    r3_reg <= ent_rd_reg[15:0];
                end
            end
        end
        if (cmd.save_prim)
        begin
            p0_reg <= r0_reg;
            p1_reg <= r1_reg;
            p2_reg <= r2_reg;
            p3_reg <= r3_reg;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.set_result)
        begin
            if (!req_reg.op)
            begin
                rsp <= '{status: cmd.res_ovf ? ST_OVERFLOW : ST_OK,
                         default: '0};
            end
            else
            begin
                rsp.status <= cmd.res_ok ? ST_OK : ST_NOT_ASSN;
                if (cmd.save_prim)
                begin
                    rsp.prim_base  <= r0_reg;
                    rsp.prim_count <= r1_reg;
                    rsp.sec_base   <= r2_reg;
                    rsp.sec_count  <= r3_reg;
                end
                else
                begin
                    rsp.prim_base  <= p0_reg;
                    rsp.prim_count <= p1_reg;
                    rsp.sec_base   <= p2_reg;
                    rsp.sec_count  <= p3_reg;
                end
            end
        end
    end
endmodule

// File: rtl/resource_range_validator.sv
// Top level of the resource range validator
//
// One item is in work at a time. A query runs one pass for the requesting
// host and, on a miss, a second pass for all_hosts_id. A pass is a binary
// search over the group index (each probe reads a group utype, then compares;
// at most floor(log2(groups)) + 1 probes) and a check step, plus, when the
// group is found, a walk of it (each entry is read, then evaluated, over one
// entry memory read port; the walk stops at the group end or once the
// secondary range is filled).
// A finished result waits in the output register and holds off the next
// transfer until it is taken.
`include "resource_range_validator_macros.svh"
module resource_range_validator import rrv_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    rrv_stream_if.sink          in_ch,
    rrv_stream_if.source        out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W+1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    cmd_t       cmd;
    sts_t       sts;
    logic [7:0] all_hosts_reg;
    logic       in_xfer;

    assign pready  = 1'b1;
    assign prdata  = (paddr[PADDR_W+1:2] == REG_ALL_HOSTS) ? {24'd0, all_hosts_reg} : 32'd0;
    assign in_xfer = in_ch.valid && in_ch.ready;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_hosts_reg <= ALL_HOSTS_RESET;
        end
        else if (psel && penable && pwrite && paddr[PADDR_W+1:2] == REG_ALL_HOSTS)
        begin
            all_hosts_reg <= pwdata[7:0];
        end
    end

    rrv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rrv_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_data      (in_ch.data),
        .all_hosts_id (all_hosts_reg),
        .sts          (sts),
        .rsp          (out_ch.data)
    );

    `RRV_ASSERT_IMP(a_acc_free, clk, rst_n, in_xfer && out_ch.valid, out_ch.ready, "accept stalled")
    `RRV_ASSERT_NEXT(a_accept_runs, clk, rst_n, in_xfer, !in_ch.ready, "accept while busy")
    `RRV_ASSERT_IMP(a_store_ok, clk, rst_n, cmd.do_store, !cmd.set_ovf, "stored and refused")
endmodule

// File: bench/testbench.sv
// Self-checking testbench for the resource range validator
module testbench;
    import rrv_pkg::*;

    typedef struct {
        req_t req;
        bit   pause;    // hold the sender until every result is back
    } pending_t;

    localparam int CYCLE_LIMIT = 20000000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W+1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rrv_stream_if #(.payload_t(req_t)) in_ch ();
    rrv_stream_if #(.payload_t(rsp_t)) out_ch ();

    resource_range_validator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the assignment table
    logic [15:0] tbl_utype [ENTRY_DEPTH];
    logic [7:0]  tbl_host  [ENTRY_DEPTH];
    logic [15:0] tbl_start [ENTRY_DEPTH];
    logic [15:0] tbl_num   [ENTRY_DEPTH];
    logic [15:0] grp_utype [GROUP_DEPTH];
    int          grp_first [GROUP_DEPTH];
    int          grp_len   [GROUP_DEPTH];
    int          tbl_cnt;
    int          grp_cnt;
    bit          tbl_ovf;
    logic [7:0]  all_hosts;

    pending_t    pend_q[$];
    pending_t    drv_item;
    rsp_t        expected_rsp_q[$];
    int          err_cnt;
    int          cycle_cnt;
    int          src_idle;
    int          snk_stall;
    int          hold_cnt;
    bit          in_fire;

    // Stimulus generator state
    logic [15:0] last_ut;
    logic [15:0] loaded_ut[$];

    // Free-running clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int find_group(logic [15:0] ut);
        int lo;
        int hi;
        int left;
        int mid;
        lo = 0;
        hi = grp_cnt - 1;
        left = grp_cnt;
        while (lo <= hi && lo < grp_cnt && hi >= 0 && hi < grp_cnt && left > 0)
        begin
            mid = (lo + hi) / 2;
            if (grp_utype[mid] == ut)
                return mid;
            if (grp_utype[mid] < ut)
                lo = mid + 1;
            else
                hi = mid - 1;
            left--;
        end
        return -1;
    endfunction

    // Returns {start, num, start_2nd, num_2nd} for one host
    function automatic logic [3:0][15:0] host_ranges(logic [7:0] h, logic [15:0] ut);
        logic [3:0][15:0] r;
        int g;
        int e;
        r = '0;
        g = find_group(ut);
        if (g < 0)
            return r;
        for (int i = 0; i < grp_len[g]; i++)
        begin
            e = grp_first[g] + i;
            if (e >= tbl_cnt)
                break;
            if (tbl_host[e] == h && tbl_utype[e] == ut)
            begin
                if (r[2] == 16'd0)
                begin
                    r[3] = tbl_start[e];
                    r[2] = tbl_num[e];
                end
                else
                begin
                    r[1] = tbl_start[e];
                    r[0] = tbl_num[e];
                    break;
                end
            end
        end
        return r;
    endfunction

    function automatic bit index_covered(logic [15:0] idx, logic [3:0][15:0] r);
        logic [16:0] i17;
        i17 = {1'b0, idx};
        return (i17 >= {1'b0, r[3]} && i17 < {1'b0, r[3]} + {1'b0, r[2]}) ||
               (i17 >= {1'b0, r[1]} && i17 < {1'b0, r[1]} + {1'b0, r[0]});
    endfunction

    // Apply one accepted item to the shadow table and return its answer
    function automatic rsp_t validate_or_load(req_t q);
        rsp_t rsp;
        bit opens;
        logic [3:0][15:0] r;
        rsp = '0;
        rsp.status = ST_OK;
        if (q.op == 1'b0)
        begin
            opens = (grp_cnt == 0) || (grp_utype[grp_cnt-1] != q.utype);
            if (tbl_ovf || tbl_cnt >= ENTRY_DEPTH || (opens && grp_cnt >= GROUP_DEPTH))
            begin
                tbl_ovf = 1'b1;
                rsp.status = ST_OVERFLOW;
            end
            else
            begin
                tbl_utype[tbl_cnt] = q.utype;
                tbl_host[tbl_cnt] = q.host;
                tbl_start[tbl_cnt] = q.entry_start;
                tbl_num[tbl_cnt] = q.entry_num;
                if (opens)
                begin
                    grp_utype[grp_cnt] = q.utype;
                    grp_first[grp_cnt] = tbl_cnt;
                    grp_len[grp_cnt] = 1;
                    grp_cnt++;
                end
                else
                    grp_len[grp_cnt-1]++;
                tbl_cnt++;
            end
        end
        else
        begin
            r = host_ranges(q.host, q.utype);
            {rsp.prim_base, rsp.prim_count, rsp.sec_base, rsp.sec_count} = r;
            if (!index_covered(q.rsrc_idx, r) &&
                !index_covered(q.rsrc_idx, host_ranges(all_hosts, q.utype)))
                rsp.status = ST_NOT_ASSN;
        end
        return rsp;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch %s: expected %h actual %h at cycle %0d", what, want, got,
                     cycle_cnt);
    endtask

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        in_fire = rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_rsp_q.size() == 0)
                note_mismatch("unexpected transfer", 32'd0, {30'd0, out_ch.data.status});
            else
            begin
                rsp_t want;
                want = expected_rsp_q.pop_front();
                if (out_ch.data.status != want.status)
                    note_mismatch("status", 32'(want.status), 32'(out_ch.data.status));
                if (out_ch.data.prim_base != want.prim_base)
                    note_mismatch("prim_base", 32'(want.prim_base),
                                  32'(out_ch.data.prim_base));
                if (out_ch.data.prim_count != want.prim_count)
                    note_mismatch("prim_count", 32'(want.prim_count),
                                  32'(out_ch.data.prim_count));
                if (out_ch.data.sec_base != want.sec_base)
                    note_mismatch("sec_base", 32'(want.sec_base),
                                  32'(out_ch.data.sec_base));
                if (out_ch.data.sec_count != want.sec_count)
                    note_mismatch("sec_count", 32'(want.sec_count),
                                  32'(out_ch.data.sec_count));
            end
        end
        if (in_fire)
            expected_rsp_q.push_back(validate_or_load(in_ch.data));
    end

    // Drive the input channel at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || in_fire))
        begin
            if (pend_q.size() > 0 && pend_q[0].pause)
            begin
                if (expected_rsp_q.size() == 0)
                    void'(pend_q.pop_front());
                in_ch.valid <= 1'b0;
            end
            else if (pend_q.size() > 0 && $urandom_range(99) >= src_idle)
            begin
                drv_item = pend_q.pop_front();
                in_ch.data <= drv_item.req;
                in_ch.valid <= 1'b1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Drive ready; a long hold-off overrides random stalls
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= rst_n && ($urandom_range(99) >= snk_stall);
    end

    task automatic push_item(bit op, logic [15:0] ut, logic [7:0] h, logic [15:0] idx,
                             logic [15:0] st, logic [15:0] num);
        pending_t p;
        p.pause = 1'b0;
        p.req = '{op: op, utype: ut, host: h, rsrc_idx: idx, entry_start: st,
                  entry_num: num};
        pend_q.push_back(p);
    endtask

    function automatic logic [7:0] pick_host();
        case ($urandom_range(5))
            0: return 8'd1;
            1: return 8'd2;
            2: return all_hosts;
            3: return 8'(~all_hosts);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(300));
        endcase
    endfunction

    task automatic push_load(bit fresh_group);
        logic [15:0] ut;
        if ($urandom_range(19) == 0)
            ut = 16'($urandom);
        else if (fresh_group || loaded_ut.size() == 0 || $urandom_range(9) < 4)
        begin
            ut = last_ut + 16'($urandom_range(1, 900));
            if (ut <= last_ut)
                ut = 16'($urandom);
            last_ut = ut;
            loaded_ut.push_back(ut);
        end
        else
            ut = last_ut;
        push_item(1'b0, ut, pick_host(), 16'($urandom), pick_value(),
                  ($urandom_range(9) == 0) ? 16'd0 : pick_value());
    endtask

    task automatic push_query();
        logic [15:0] ut;
        logic [15:0] idx;
        int e;
        if (loaded_ut.size() > 0 && $urandom_range(9) < 8)
            ut = loaded_ut[$urandom_range(loaded_ut.size() - 1)];
        else
            ut = 16'($urandom);
        idx = 16'($urandom);
        if (tbl_cnt > 0 && $urandom_range(3) != 0)
        begin
            // land on or next to the edges of a stored range
            e = $urandom_range(tbl_cnt - 1);
            case ($urandom_range(3))
                0: idx = tbl_start[e];
                1: idx = tbl_start[e] - 16'd1;
                2: idx = tbl_start[e] + tbl_num[e] - 16'd1;
                default: idx = tbl_start[e] + tbl_num[e];
            endcase
            if ($urandom_range(1) == 0)
                ut = tbl_utype[e];
        end
        push_item(1'b1, ut, pick_host(), idx, 16'($urandom), 16'($urandom));
    endtask

    task automatic push_pause();
        pending_t p;
        p.pause = 1'b1;
        p.req = '0;
        pend_q.push_back(p);
    endtask

    task automatic apb_write(logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= (PADDR_W + 2)'({REG_ALL_HOSTS, 2'b00});
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite <= 1'b0;
        all_hosts = value[7:0];
        @(negedge clk);
        @(posedge clk);
        if (prdata[7:0] != all_hosts)
            note_mismatch("all_hosts_id readback", {24'd0, all_hosts}, prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || expected_rsp_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] ah_set[4];
        int idle_set[4];
        int stall_set[4];
        ah_set = '{8'd0, 8'd255, 8'($urandom), 8'd128};
        idle_set = '{0, 53, 0, 15};
        stall_set = '{0, 0, 53, 15};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        err_cnt = 0;
        cycle_cnt = 0;
        hold_cnt = 0;
        src_idle = 0;
        snk_stall = 0;
        in_fire = 1'b0;
        tbl_cnt = 0;
        grp_cnt = 0;
        tbl_ovf = 1'b0;
        all_hosts = ALL_HOSTS_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        apb_write(32'd128);

        // Directed: empty table, zero-count primary, secondary, all-hosts, 17-bit sum
        push_item(1'b1, 16'h0000, 8'd0, 16'd0, 16'd0, 16'd0);
        push_item(1'b0, 16'h0000, 8'd0, 16'd0, 16'd0, 16'd0);
        push_item(1'b0, 16'h0000, 8'd0, 16'd0, 16'd10, 16'd5);
        push_item(1'b0, 16'h0000, 8'd0, 16'd0, 16'd40, 16'd2);
        push_item(1'b0, 16'h0000, 8'd0, 16'd0, 16'd90, 16'd9);
        push_item(1'b0, 16'h0005, 8'd128, 16'd0, 16'd100, 16'd10);
        push_item(1'b0, 16'h0010, 8'd255, 16'd0, 16'hFFFF, 16'hFFFF);
        push_item(1'b1, 16'h0000, 8'd0, 16'd10, 16'd0, 16'd0);
        push_item(1'b1, 16'h0000, 8'd0, 16'd14, 16'd0, 16'd0);
        push_item(1'b1, 16'h0000, 8'd0, 16'd15, 16'd0, 16'd0);
        push_item(1'b1, 16'h0000, 8'd0, 16'd41, 16'd0, 16'd0);
        push_item(1'b1, 16'h0000, 8'd0, 16'd9, 16'd0, 16'd0);
        push_item(1'b1, 16'h0005, 8'd7, 16'd105, 16'd0, 16'd0);
        push_item(1'b1, 16'h0005, 8'd7, 16'd110, 16'd0, 16'd0);
        push_item(1'b1, 16'h0005, 8'd128, 16'd200, 16'd0, 16'd0);
        push_item(1'b1, 16'h0010, 8'd255, 16'hFFFF, 16'd0, 16'd0);
        push_item(1'b1, 16'h0010, 8'd255, 16'd0, 16'd0, 16'd0);
        push_item(1'b1, 16'h0003, 8'd0, 16'd0, 16'd0, 16'd0);
        push_item(1'b1, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        last_ut = 16'h0010;
        loaded_ut = '{16'h0000, 16'h0005, 16'h0010};
        drain();

        // Random phases, each with its own idling and all-hosts setting
        for (int ph = 0; ph < 4; ph++)
        begin
            apb_write({24'd0, ah_set[ph]});
            src_idle = idle_set[ph];
            snk_stall = stall_set[ph];
            if (ph == 0)
                hold_cnt = 400;
            for (int n = 0; n < 400; n++)
            begin
                if (ph == 1 && n == 200)
                    push_pause();
                if ((ph == 0 && $urandom_range(9) < 5) || $urandom_range(9) == 0)
                    push_load($urandom_range(2) == 0);
                else
                    push_query();
            end
            // open groups until the index overflows
            if (ph == 3)
            begin
                for (int n = 0; n < 70; n++)
                    push_load(1'b1);
                for (int n = 0; n < 30; n++)
                    push_query();
            end
            drain();
        end

        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: resource_range_validator.f
+incdir+rtl
rtl/rrv_pkg.sv
rtl/rrv_stream_if.sv
rtl/rrv_ctrl.sv
rtl/rrv_datapath.sv
rtl/resource_range_validator.sv
bench/testbench.sv
